>>> hw/rtl/uhbc_pkg.sv
// ----------------------------------------------------------------------------
// uhbc_pkg
// shared types and constants for the unique hit block chainer
// ----------------------------------------------------------------------------
`default_nettype none

package uhbc_pkg;

    localparam int unsigned QUERY_SEEDS   = 1048576;
    localparam int unsigned HIT_W         = 21;
    localparam logic [HIT_W-1:0] HITS_MAX = HIT_W'(QUERY_SEEDS);

    localparam int unsigned TOL_W         = 10;
    localparam int unsigned MIN_W         = 8;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(50);
    localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(2);

    localparam int unsigned FIFO_DEPTH    = 4;
    localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    // register map
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_MIN_HITS  = 1'b1;

    typedef struct packed {
        logic [19:0] seed_rank;
        logic [23:0] query_pos;
        logic        unique_hit;
        logic [25:0] ref_entry;
        logic [15:0] ref_seq;
        logic [31:0] ref_offset;
        logic        query_end;
    } t_in_word;

    typedef struct packed {
        logic [23:0]      start_query_pos;
        logic [23:0]      end_query_pos;
        logic [15:0]      block_seq;
        logic [31:0]      start_ref_offset;
        logic [31:0]      end_ref_offset;
        logic [HIT_W-1:0] hit_count;
        logic [25:0]      entry_span;
        logic             query_done;
    } t_out_word;

    // results written to the output queue for one hit
    typedef struct packed {
        logic first;   // closed block
        logic second;  // block flushed at query end
    } t_push_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/uhbc_core.sv
// ----------------------------------------------------------------------------
// uhbc_core
// open block state and chaining decision, one hit per cycle while i_go is high
// ----------------------------------------------------------------------------
`default_nettype none

module uhbc_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_go,
    input  wire uhbc_pkg::t_in_word         i_in,
    input  wire logic [uhbc_pkg::TOL_W-1:0] i_tol,
    input  wire logic [uhbc_pkg::MIN_W-1:0] i_min,
    output uhbc_pkg::t_push_ctl             o_push,
    output uhbc_pkg::t_out_word             o_res0,
    output uhbc_pkg::t_out_word             o_res1
);
    import uhbc_pkg::*;

    logic               r_open,        n_open;
    logic [25:0]        r_first_entry, n_first_entry;
    logic [25:0]        r_last_entry,  n_last_entry;
    logic [19:0]        r_first_rank,  n_first_rank;
    logic [23:0]        r_first_pos,   n_first_pos;
    logic [23:0]        r_last_pos,    n_last_pos;
    logic [15:0]        r_seq,         n_seq;
    logic [31:0]        r_first_off,   n_first_off;
    logic [31:0]        r_last_off,    n_last_off;
    logic [HIT_W-1:0]   r_hits,        n_hits;
    logic [25:0]        r_span,        n_span;
    logic signed [20:0] r_rdiff,       n_rdiff;
    logic               r_dir_up,      n_dir_up;
    logic               r_dir_dn,      n_dir_dn;

    logic signed [27:0] drift;
    logic signed [27:0] tol_s;
    logic               too_large;
    logic               end_block;
    logic               emit0;
    logic               emit1;
    logic [HIT_W-1:0]   hits_base;
    logic               cont_up;
    logic               cont_dn;
    logic [25:0]        cont_span;
    logic signed [20:0] cont_rdiff;
    logic [HIT_W-1:0]   min_ext;

    assign min_ext = HIT_W'(i_min);

    // drift of the open block between entry span and rank span
    assign drift     = $signed({2'b00, r_span}) - 28'(r_rdiff);
    assign tol_s     = $signed({18'd0, i_tol});
    assign too_large = (drift > tol_s) || (drift < -tol_s);

    assign end_block = !r_open || (i_in.ref_seq != r_seq)
                     || (r_dir_up && ((i_in.ref_entry < r_last_entry) || too_large))
                     || (r_dir_dn && ((i_in.ref_entry > r_last_entry) || too_large));

    // span and rank difference if the hit extends the open block
    assign cont_up    = i_in.ref_entry > r_first_entry;
    assign cont_dn    = i_in.ref_entry < r_first_entry;
    assign cont_span  = cont_up ? (i_in.ref_entry - r_first_entry)
                                : (r_first_entry - i_in.ref_entry);
    assign cont_rdiff = $signed({1'b0, i_in.seed_rank}) - $signed({1'b0, r_first_rank});

    assign emit0 = i_in.unique_hit && end_block && r_open && (r_hits > min_ext);

    always_comb begin
        n_open        = r_open;
        n_first_entry = r_first_entry;
        n_last_entry  = r_last_entry;
        n_first_rank  = r_first_rank;
        n_first_pos   = r_first_pos;
        n_last_pos    = r_last_pos;
        n_seq         = r_seq;
        n_first_off   = r_first_off;
        n_last_off    = r_last_off;
        n_hits        = r_hits;
        n_span        = r_span;
        n_rdiff       = r_rdiff;
        n_dir_up      = r_dir_up;
        n_dir_dn      = r_dir_dn;
        hits_base     = r_hits;
        if (i_in.unique_hit) begin
            if (end_block) begin
                n_open        = 1'b1;
                hits_base     = '0;
                n_first_entry = i_in.ref_entry;
                n_first_rank  = i_in.seed_rank;
                n_first_pos   = i_in.query_pos;
                n_first_off   = i_in.ref_offset;
                n_seq         = i_in.ref_seq;
                n_span        = '0;
                n_rdiff       = '0;
                n_dir_up      = 1'b0;
                n_dir_dn      = 1'b0;
            end else begin
                n_span        = cont_span;
                n_rdiff       = cont_rdiff;
                n_dir_up      = cont_up;
                n_dir_dn      = cont_dn;
            end
            n_hits       = (hits_base < HITS_MAX) ? hits_base + HIT_W'(1) : hits_base;
            n_last_entry = i_in.ref_entry;
            n_last_pos   = i_in.query_pos;
            n_last_off   = i_in.ref_offset;
        end
    end

    assign emit1 = i_in.query_end && n_open && (n_hits > min_ext);

    always_comb begin
        o_res0.start_query_pos  = r_first_pos;
        o_res0.end_query_pos    = r_last_pos;
        o_res0.block_seq        = r_seq;
        o_res0.start_ref_offset = r_first_off;
        o_res0.end_ref_offset   = r_last_off;
        o_res0.hit_count        = r_hits;
        o_res0.entry_span       = r_span;
        o_res0.query_done       = 1'b0;

        o_res1.start_query_pos  = n_first_pos;
        o_res1.end_query_pos    = n_last_pos;
        o_res1.block_seq        = n_seq;
        o_res1.start_ref_offset = n_first_off;
        o_res1.end_ref_offset   = n_last_off;
        o_res1.hit_count        = n_hits;
        o_res1.entry_span       = n_span;
        o_res1.query_done       = 1'b1;

        o_push.first  = i_go && emit0;
        o_push.second = i_go && emit1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_hits   <= '0;
            r_dir_up <= 1'b0;
            r_dir_dn <= 1'b0;
            r_span   <= '0;
            r_rdiff  <= '0;
        end else if (i_go) begin
            if (i_in.query_end) begin
                r_open   <= 1'b0;
                r_hits   <= '0;
                r_dir_up <= 1'b0;
                r_dir_dn <= 1'b0;
                r_span   <= '0;
                r_rdiff  <= '0;
            end else begin
                r_open   <= n_open;
                r_hits   <= n_hits;
                r_dir_up <= n_dir_up;
                r_dir_dn <= n_dir_dn;
                r_span   <= n_span;
                r_rdiff  <= n_rdiff;
            end
        end
    end

    // block payload, only read while the block is open
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_first_entry <= n_first_entry;
            r_last_entry  <= n_last_entry;
            r_first_rank  <= n_first_rank;
            r_first_pos   <= n_first_pos;
            r_last_pos    <= n_last_pos;
            r_seq         <= n_seq;
            r_first_off   <= n_first_off;
            r_last_off    <= n_last_off;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/uhbc_fifo.sv
// ----------------------------------------------------------------------------
// uhbc_fifo
// result queue taking up to two words a cycle and giving one unless stalled
// ----------------------------------------------------------------------------
`default_nettype none

module uhbc_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire uhbc_pkg::t_push_ctl  i_push,
    input  wire uhbc_pkg::t_out_word  i_word0,
    input  wire uhbc_pkg::t_out_word  i_word1,
    output logic                      o_room,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output uhbc_pkg::t_out_word       o_word
);
    import uhbc_pkg::*;

    t_out_word            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0]   r_count,  n_count;
    logic [FIFO_AW-1:0]   wr_addr1;
    logic                 pop;

    assign o_valid  = r_count != '0;
    assign o_word   = r_mem[r_rd_ptr];
    assign o_room   = r_count <= FIFO_CW'(FIFO_DEPTH - 2);
    assign pop      = o_valid && !i_stall;
    assign wr_addr1 = i_push.first ? r_wr_ptr + FIFO_AW'(1) : r_wr_ptr;

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push.first) + FIFO_AW'(i_push.second);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
        n_count  = r_count + FIFO_CW'(i_push.first) + FIFO_CW'(i_push.second)
                 - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr_ptr] <= i_word0;
        end
        if (i_push.second) begin
            r_mem[wr_addr1] <= i_word1;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/unique_hit_block_chainer.sv
// ----------------------------------------------------------------------------
// unique_hit_block_chainer
// chains unique seed hits of a query into colinear reference blocks
// ----------------------------------------------------------------------------
// One hit word is taken every clock cycle while o_in_stall is low. A hit waits
// in the input register, where the chaining decision and the block update are
// made, and its results are registered in a four-word output queue whose head
// drives the output. A hit gives up to two result words (the closed block,
// then the block flushed at query end), so the input stalls while the queue
// has fewer than two free slots; with the output taking one word a cycle the
// rate is one hit per cycle. Registers: 0x0 drift tolerance (10 bits, reset
// 50), 0x4 minimum hit count, exclusive (8 bits, reset 2).
// ----------------------------------------------------------------------------
`default_nettype none

module unique_hit_block_chainer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // hit words
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire uhbc_pkg::t_in_word   i_in_data,
    // block words
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output uhbc_pkg::t_out_word       o_out_data,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import uhbc_pkg::*;

    logic [TOL_W-1:0] r_tol;
    logic [MIN_W-1:0] r_min;
    logic             r_in_valid;
    t_in_word         r_in;
    logic             room;
    logic             go;
    t_push_ctl        push;
    t_out_word        res0;
    t_out_word        res1;
    logic             reg_sel;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_comb begin
        case (reg_sel)
            REG_TOLERANCE: prdata = 32'(r_tol);
            REG_MIN_HITS:  prdata = 32'(r_min);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_min <= MIN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_TOLERANCE: r_tol <= pwdata[TOL_W-1:0];
                REG_MIN_HITS:  r_min <= pwdata[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign go         = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    uhbc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_in    (r_in),
        .i_tol   (r_tol),
        .i_min   (r_min),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    uhbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word0 (res0),
        .i_word1 (res1),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_data)
    );

`ifndef SYNTHESIS
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_no_push_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !go |-> (!push.first && !push.second))
        else $error("result written without a hit in progress");

    a_closed_block_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.first |-> r_in.unique_hit)
        else $error("block closed by a non-unique seed");

    a_flush_needs_query_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.second |-> r_in.query_end)
        else $error("block flushed without query end");

    a_config_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_tol == TOL_RESET && r_min == MIN_RESET))
        else $error("configuration not at reset values");
`endif

endmodule

`default_nettype wire
